@@ design/windowed_average_peak_hold_core_assert.svh @@
// Assertion macros used by the checker file wap_chk.sv.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef WINDOWED_AVERAGE_PEAK_HOLD_CORE_ASSERT_SVH
`define WINDOWED_AVERAGE_PEAK_HOLD_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define WAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/wap_pkg.sv @@
package wap_pkg;

    // Signed Q8.8 amplitude
    localparam int SAMPLE_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

@@ design/wap_ring.sv @@
module wap_ring #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output wap_pkg::sample_t     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  wap_pkg::sample_t     wr_data
);
    import wap_pkg::*;

    sample_t mem [DEPTH];
    sample_t rd_data_reg;

    // Write the new sample into its slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read of the sample leaving the window
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/wap_div.sv @@
module wap_div #(
    parameter int SUM_W = 24,
    parameter int CNT_W = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output wap_pkg::sample_t        quotient
);
    import wap_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                neg_reg;
    logic [CNT_W-1:0]    divisor_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    quo_reg;

    logic [CNT_W:0]      trial;
    logic                fits;
    logic [CNT_W:0]      diff;
    logic [CNT_W-1:0]    rem_next;
    logic [SUM_W-1:0]    mag_start;
    logic [SUM_W-1:0]    quo_signed;

    // One restoring step: shift in the next dividend bit and try the divisor
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        fits     = trial >= {1'b0, divisor_reg};
        diff     = trial - {1'b0, divisor_reg};
        rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    assign mag_start = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

    // Control: count quotient bits, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend magnitude shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg     <= dividend[SUM_W-1];
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= mag_start;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    // Restore the sign; truncation toward zero falls out of magnitude division
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = sample_t'(quo_signed[SAMPLE_W-1:0]);
    assign done       = done_reg;

endmodule

@@ design/windowed_average_peak_hold_core.sv @@
// Channel  Direction  Handshake             Word
// -------  ---------  --------------------  -----------------------------------------
// in       input      in_valid / in_stall   sample
// out      output     out_valid / out_stall latest/average/peak_amplitude, window_full
// cfg      input      cfg_write             cfg_data (hold_peak)
//
// Each word passes through S_UPDATE, S_DIV and S_OUT from accept to result; the serial
// divider, one quotient bit per cycle, runs while the word is in S_DIV.
// in_stall is high from the accept until the result is in the output register.
// A result held by out_stall keeps the next word out only once it is finished.
// Reset clears sum, peak, slot and wrap flag and sets hold_peak; ring contents are
// undefined and are used only after the ring has wrapped.
module windowed_average_peak_hold_core #(
    parameter int HISTORY_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  wap_pkg::sample_t  sample,
    output logic              out_valid,
    input  logic              out_stall,
    output wap_pkg::sample_t  latest_amplitude,
    output wap_pkg::sample_t  average_amplitude,
    output wap_pkg::sample_t  peak_amplitude,
    output logic              window_full
);
    import wap_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    wrapped_reg;
    logic signed [SUM_W-1:0] sum_reg;
    sample_t                 peak_reg;
    logic                    hold_peak_reg;
    sample_t                 sample_reg;
    logic                    out_valid_reg;
    sample_t                 out_latest_reg;
    sample_t                 out_average_reg;
    sample_t                 out_peak_reg;
    logic                    out_full_reg;

    logic                    in_accept;
    logic                    out_free;
    sample_t                 old_sample;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] sum_next;
    logic                    peak_take;
    logic [CNT_W-1:0]        count;
    logic                    last_slot;
    logic                    div_done;
    sample_t                 div_quotient;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;

    // Sample history
    wap_ring #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (slot_reg),
        .rd_data (old_sample),
        .wr_en   (state_reg == S_UPDATE),
        .wr_addr (slot_reg),
        .wr_data (sample_reg)
    );

    // Window sum, peak decision and sample count for this word
    always_comb
    begin
        old_ext   = wrapped_reg ? SUM_W'(old_sample) : '0;
        sum_next  = sum_reg - old_ext + SUM_W'(sample_reg);
        peak_take = hold_peak_reg
                    && (((slot_reg == '0) && !wrapped_reg) || (sample_reg > peak_reg));
        count     = wrapped_reg ? CNT_W'(HISTORY_DEPTH) : (CNT_W'(slot_reg) + CNT_W'(1));
        last_slot = slot_reg == SLOT_W'(HISTORY_DEPTH - 1);
    end

    // Mean = sum / count
    wap_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_UPDATE),
        .dividend (sum_next),
        .divisor  (count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer, running state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_reg        <= '0;
            wrapped_reg     <= 1'b0;
            sum_reg         <= '0;
            peak_reg        <= '0;
            hold_peak_reg   <= 1'b1;
            sample_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_latest_reg  <= '0;
            out_average_reg <= '0;
            out_peak_reg    <= '0;
            out_full_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                hold_peak_reg <= cfg_data;
            end

            // Drop the taken result word unless a new one replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample;
                        state_reg  <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    sum_reg <= sum_next;
                    if (peak_take)
                    begin
                        peak_reg <= sample_reg;
                    end
                    if (last_slot)
                    begin
                        slot_reg    <= '0;
                        wrapped_reg <= 1'b1;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_latest_reg  <= sample_reg;
                        out_average_reg <= div_quotient;
                        out_peak_reg    <= peak_reg;
                        out_full_reg    <= wrapped_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign latest_amplitude  = out_latest_reg;
    assign average_amplitude = out_average_reg;
    assign peak_amplitude    = out_peak_reg;
    assign window_full       = out_full_reg;

endmodule

@@ design/wap_chk.sv @@
`include "windowed_average_peak_hold_core_assert.svh"

module wap_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              window_full
);

    // A stalled result word stays offered
    `WAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")

    // After a word is taken the block is busy with it
    `WAP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy")

    // A result never appears right after an accept: the word must still pass the update and the divide
    `WAP_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "early")

    // Once the window is full it stays full
    `WAP_ASSERT_NOW(a_full_sticky, 1'b1, !$fell(window_full), "window_full dropped")

endmodule

bind windowed_average_peak_hold_core wap_chk u_wap_chk (.*);
